FILE: hw/rtl/keyframe_path_interpolator_defines.svh
// Assertion macros shared by the checker of the keyframe path interpolator.
`ifndef KEYFRAME_PATH_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_PATH_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define KPI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyframe path interpolator check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define KPI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyframe path interpolator check failed");

`endif

FILE: hw/rtl/kpi_pkg.sv
// Shared types, codes and defaults of the keyframe path interpolator.
package kpi_pkg;

	localparam int MAX_KEYS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_COMP      = 6;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] CFG_START_DELAY = 2'd0;
	localparam logic [1:0] CFG_KEY_COUNT   = 2'd1;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         key_slot;
		logic [31:0]        key_time;
		logic signed [31:0] key_pos_x;
		logic signed [31:0] key_pos_y;
		logic signed [31:0] key_pos_z;
		logic signed [31:0] key_tgt_x;
		logic signed [31:0] key_tgt_y;
		logic signed [31:0] key_tgt_z;
		logic [31:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic signed [31:0] look_x;
		logic signed [31:0] look_y;
		logic signed [31:0] look_z;
		logic               finished;
	} out_item_t;

	typedef logic [NUM_COMP-1:0][31:0] pts_t;

	typedef struct packed {
		logic load_wr;
		logic tick;
		logic rd_last;
		logic rd_idx;
		logic rd_next;
		logic cap_cur;
		logic advance;
		logic div_init;
		logic div_step;
		logic mul;
		logic sub;
		logic emit_last;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic tick_go;
		logic last_end;
		logic adv;
		logic div_done;
		logic comp_last;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/kpi_ctrl.sv
// Sequencer of the keyframe path interpolator.
module kpi_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  opcode,
	output logic                  in_ready,
	input  kpi_pkg::sts_t         sts,
	output kpi_pkg::cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_LAST, ST_CHK_LAST, ST_CUR, ST_CHK, ST_NXT,
		ST_DIV_INIT, ST_DIV_RUN, ST_MUL, ST_SUB, ST_EMIT
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == kpi_pkg::OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.tick = 1'b1;
						if (sts.tick_go) state_d = ST_RD_LAST;
					end
				end
			end
			ST_RD_LAST: begin
				cmd.rd_last = 1'b1;
				state_d     = ST_CHK_LAST;
			end
			ST_CHK_LAST: begin
				if (sts.last_end) begin
					if (sts.out_free) begin
						cmd.emit_last = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.rd_idx = 1'b1;
					state_d    = ST_CUR;
				end
			end
			ST_CUR: begin
				cmd.cap_cur = 1'b1;
				state_d     = ST_CHK;
			end
			ST_CHK: begin
				if (sts.adv) begin
					cmd.rd_next = 1'b1;
					state_d     = ST_NXT;
				end else begin
					state_d = ST_DIV_INIT;
				end
			end
			ST_NXT: begin
				cmd.advance = 1'b1;
				state_d     = ST_CHK;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (sts.div_done) begin
					state_d = ST_MUL;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = sts.comp_last ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/kpi_dpath.sv
// Datapath of the keyframe path interpolator: tables, walk, divider and blend.
module kpi_dpath #(
	parameter int MAX_KEYS  = kpi_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kpi_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  kpi_pkg::in_item_t   in_item,
	input  kpi_pkg::cmd_t       cmd,
	output kpi_pkg::sts_t       sts,
	input  logic                out_ready,
	output logic                out_valid,
	output kpi_pkg::out_item_t  out_item
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int NW = $clog2(MAX_KEYS + 1);
	localparam int FW = FRAC_BITS + 1;
	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam int PW = 35 + FRAC_BITS;
	localparam logic [FW-1:0] ONE_FACTOR = FW'(1) << FRAC_BITS;

	logic [31:0]        key_mem [MAX_KEYS];
	kpi_pkg::pts_t      pts_mem [MAX_KEYS];
	logic [31:0]        kt_rd_q;
	kpi_pkg::pts_t      pts_rd_q;

	logic [31:0]        start_delay_q;
	logic [4:0]         key_count_q;
	logic               started_q;
	logic               done_q;
	logic [31:0]        anchor_q;
	logic [31:0]        t_q;
	logic [AW-1:0]      idx_q;
	logic [31:0]        kt_cur_q;
	logic signed [31:0] cur_q [kpi_pkg::NUM_COMP];
	logic signed [32:0] delta_q [kpi_pkg::NUM_COMP];
	logic [31:0]        interval_q;
	logic [32:0]        rem_q;
	logic [FW-1:0]      factor_q;
	logic [CW-1:0]      cnt_q;
	logic [2:0]         comp_q;
	logic signed [PW-1:0] prod_s1;
	logic signed [31:0] res_q [kpi_pkg::NUM_COMP];
	kpi_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [NW-1:0]      n_w;
	logic [NW:0]        idx_p1;
	logic [NW:0]        idx_p2;
	logic [NW:0]        n_x;
	logic [31:0]        elapsed_w;
	logic [AW-1:0]      slot_a;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      nxt_addr;
	kpi_pkg::pts_t      in_pts;
	kpi_pkg::pts_t      mid_pts;
	logic [31:0]        rem_w;
	logic [32:0]        rem_sh;
	logic signed [PW-1:0] d_ext;
	logic signed [PW-1:0] f_ext;
	logic signed [PW-1:0] diff_w;
	logic signed [31:0] sat_w;
	logic               mid_en;

	always_comb begin
		if (key_count_q == 5'd0) begin
			n_w = NW'(1);
		end else if (32'(key_count_q) > MAX_KEYS) begin
			n_w = NW'(MAX_KEYS);
		end else begin
			n_w = NW'(key_count_q);
		end
	end

	assign n_x      = (NW + 1)'(n_w);
	assign idx_p1   = (NW + 1)'(idx_q) + (NW + 1)'(1);
	assign idx_p2   = (NW + 1)'(idx_q) + (NW + 1)'(2);
	assign nxt_addr = AW'(idx_p1);
	assign mid_en   = n_x > idx_p2;
	assign slot_a   = AW'(in_item.key_slot);

	assign elapsed_w = started_q ? (in_item.now_ms - anchor_q) : 32'd0;

	assign in_pts = {in_item.key_tgt_z, in_item.key_tgt_y, in_item.key_tgt_x,
		in_item.key_pos_z, in_item.key_pos_y, in_item.key_pos_x};

	always_comb begin
		for (int c = 0; c < kpi_pkg::NUM_COMP; c++) begin
			mid_pts[c] = 32'(($signed({pts_rd_q[c][31], pts_rd_q[c]})
				+ $signed({cur_q[c][31], cur_q[c]})) >>> 1);
		end
	end

	always_comb begin
		if (cmd.rd_last) begin
			rd_addr = AW'(n_w - NW'(1));
		end else if (cmd.rd_next) begin
			rd_addr = nxt_addr;
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && (32'(in_item.key_slot) < MAX_KEYS)) begin
			key_mem[slot_a] <= in_item.key_time;
			pts_mem[slot_a] <= in_pts;
		end else if (cmd.advance && mid_en) begin
			pts_mem[idx_q + AW'(1)] <= mid_pts;
		end
		if (cmd.rd_last || cmd.rd_idx || cmd.rd_next) begin
			kt_rd_q  <= key_mem[rd_addr];
			pts_rd_q <= pts_mem[rd_addr];
		end
	end

	assign rem_w  = kt_cur_q - t_q;
	assign rem_sh = {rem_q[31:0], 1'b0};

	assign d_ext  = PW'(delta_q[comp_q]);
	assign f_ext  = PW'({1'b0, factor_q});
	assign diff_w = PW'(cur_q[comp_q]) - (prod_s1 >>> FRAC_BITS);

	always_comb begin
		if ((diff_w[PW-1:31] != '0) && (diff_w[PW-1:31] != '1)) begin
			sat_w = diff_w[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_w = diff_w[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			t_q <= elapsed_w - start_delay_q;
		end
		if (cmd.cap_cur) begin
			kt_cur_q <= kt_rd_q;
			for (int c = 0; c < kpi_pkg::NUM_COMP; c++) begin
				cur_q[c] <= pts_rd_q[c];
			end
		end else if (cmd.advance) begin
			kt_cur_q <= kt_rd_q;
			for (int c = 0; c < kpi_pkg::NUM_COMP; c++) begin
				cur_q[c] <= mid_en ? mid_pts[c] : pts_rd_q[c];
			end
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, rem_w};
		end else if (cmd.div_step) begin
			rem_q <= (rem_sh >= {1'b0, interval_q}) ? rem_sh - {1'b0, interval_q} : rem_sh;
		end
		if (cmd.mul) begin
			prod_s1 <= d_ext * f_ext;
		end
		if (cmd.sub) begin
			res_q[comp_q] <= sat_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= '0;
			key_count_q   <= 5'd1;
			started_q     <= 1'b0;
			done_q        <= 1'b0;
			anchor_q      <= '0;
			idx_q         <= '0;
			interval_q    <= '0;
			factor_q      <= '0;
			cnt_q         <= '0;
			comp_q        <= '0;
			out_valid_q   <= 1'b0;
			for (int c = 0; c < kpi_pkg::NUM_COMP; c++) begin
				delta_q[c] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					kpi_pkg::CFG_START_DELAY: start_delay_q <= cfg_data;
					kpi_pkg::CFG_KEY_COUNT:   key_count_q   <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.tick && !started_q) begin
				started_q <= 1'b1;
				anchor_q  <= in_item.now_ms;
			end
			if (cmd.advance) begin
				for (int c = 0; c < kpi_pkg::NUM_COMP; c++) begin
					delta_q[c] <= $signed({mid_en ? mid_pts[c][31] : pts_rd_q[c][31],
						mid_en ? mid_pts[c] : pts_rd_q[c]}) - $signed({cur_q[c][31], cur_q[c]});
				end
				interval_q <= kt_rd_q - kt_cur_q;
				idx_q      <= nxt_addr;
			end
			if (cmd.div_init) begin
				comp_q <= '0;
				if (interval_q == 32'd0) begin
					factor_q <= '0;
					cnt_q    <= '0;
				end else if (rem_w >= interval_q) begin
					factor_q <= ONE_FACTOR;
					cnt_q    <= '0;
				end else begin
					factor_q <= '0;
					cnt_q    <= CW'(FRAC_BITS);
				end
			end else if (cmd.div_step) begin
				factor_q <= {factor_q[FW-2:0], rem_sh >= {1'b0, interval_q}};
				cnt_q    <= cnt_q - CW'(1);
			end
			if (cmd.sub) begin
				comp_q <= comp_q + 3'd1;
			end
			if (cmd.emit_last) begin
				done_q <= 1'b1;
			end
			if (cmd.emit || cmd.emit_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_last) begin
			out_q <= {pts_rd_q[0], pts_rd_q[1], pts_rd_q[2], pts_rd_q[3], pts_rd_q[4],
				pts_rd_q[5], 1'b1};
		end else if (cmd.emit) begin
			out_q <= {res_q[0], res_q[1], res_q[2], res_q[3], res_q[4], res_q[5], 1'b0};
		end
	end

	assign sts.tick_go   = !done_q && (elapsed_w > start_delay_q);
	assign sts.last_end  = (n_w == NW'(1)) || (kt_rd_q < t_q);
	assign sts.adv       = (n_x > idx_p1) && (kt_cur_q <= t_q);
	assign sts.div_done  = (cnt_q == '0);
	assign sts.comp_last = (comp_q == 3'(kpi_pkg::NUM_COMP - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: hw/rtl/keyframe_path_interpolator.sv
// Top level of the keyframe path interpolator.
// Input channel in_valid/in_ready/in_item carries loads and ticks. A load
// writes one keyframe slot, produces nothing and leaves the block idle. A
// tick that produces nothing (before the start delay is over or after the
// path has finished) also leaves the block idle.
// A tick that produces a result runs the sequencer: it reads the last key,
// walks the keyframes one by one (states ST_CHK and ST_NXT), runs a
// restoring divide of up to FRAC_BITS steps and blends the six components
// one by one (states ST_MUL and ST_SUB), one multiplier shared. When the
// last key is already passed, it emits that key with finished set instead.
// The result channel out_valid/out_ready/out_item is a registered stage; a
// new transaction is accepted while a result waits, and a stalled receiver
// only holds the next result back. The configuration port is always ready
// and the user writes it only while the block is idle; nothing enforces it.
// Reset clears the path state and sets start_delay to 0 and key_count to 1;
// the keyframe tables hold nothing defined until loaded.
module keyframe_path_interpolator #(
	parameter int MAX_KEYS  = kpi_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kpi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  kpi_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output kpi_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	kpi_pkg::cmd_t cmd;
	kpi_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	kpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_item.opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kpi_dpath #(
		.MAX_KEYS  (MAX_KEYS),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

FILE: hw/rtl/kpi_chk.sv
// Port checker of the keyframe path interpolator and its binding.
`include "keyframe_path_interpolator_defines.svh"

module kpi_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input kpi_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input kpi_pkg::out_item_t out_item
);

	`KPI_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready))
	`KPI_ASSERT_NEXT(a_load_quick, in_valid && in_ready && (in_item.opcode == kpi_pkg::OP_LOAD), in_ready)
	`KPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
	`KPI_ASSERT_NEXT(a_finished_last, out_valid && out_ready && out_item.finished, !out_valid)

endmodule

bind keyframe_path_interpolator kpi_chk u_kpi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
